>>> rtl/pws_pkg.sv
package pws_pkg;

    localparam int MAX_CANDIDATES = 32;
    localparam int NUM_GROUPS     = 8;

    localparam int ACTION_W = 16;
    localparam int GROUP_W  = 3;
    localparam int PRIO_W   = 8;

    localparam logic [GROUP_W-1:0] GROUP_NONE = '0;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [GROUP_W-1:0]  group;
        logic [PRIO_W-1:0]   prio;
    } t_entry;

    // Row-wide control broadcast to every cell
    typedef struct packed {
        logic insert;
        logic pop;
    } t_cell_ctrl;

    // True when a strictly precedes b: higher priority, then lower action id
    function automatic logic cand_before(input t_entry a, input t_entry b);
        logic res;
        if (a.prio != b.prio) begin
            res = (a.prio > b.prio);
        end else begin
            res = (a.action < b.action);
        end
        return res;
    endfunction

    // One-hot taken bit for a group, folded modulo the group count
    function automatic logic [NUM_GROUPS-1:0] group_bit(input logic [GROUP_W-1:0] grp);
        logic [NUM_GROUPS-1:0] mask;
        mask = '0;
        for (int k = 0; k < (1 << GROUP_W); k++) begin
            if (grp == GROUP_W'(k)) begin
                mask = NUM_GROUPS'(1) << (k % NUM_GROUPS);
            end
        end
        return mask;
    endfunction

endpackage

>>> rtl/pws_cell.sv
module pws_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pws_pkg::t_entry     i_cand,
    input  pws_pkg::t_cell_ctrl i_ctrl,
    input  pws_pkg::t_entry     i_prev_entry,
    input  logic                i_prev_valid,
    input  logic                i_prev_ins,
    input  pws_pkg::t_entry     i_next_entry,
    input  logic                i_next_valid,
    output pws_pkg::t_entry     o_entry,
    output logic                o_valid,
    output logic                o_ins
);
    import pws_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    logic   r_valid;
    logic   n_valid;

    // New item belongs at or above this slot
    assign o_ins   = !r_valid || cand_before(i_cand, r_entry);
    assign o_entry = r_entry;
    assign o_valid = r_valid;

    // Pop shifts toward the head; insert shifts toward the tail
    always_comb begin
        n_entry = r_entry;
        n_valid = r_valid;
        if (i_ctrl.pop) begin
            n_entry = i_next_entry;
            n_valid = i_next_valid;
        end else if (i_ctrl.insert) begin
            if (i_prev_ins && i_prev_valid) begin
                n_entry = i_prev_entry;
                n_valid = 1'b1;
            end else if (o_ins && !i_prev_ins) begin
                n_entry = i_cand;
                n_valid = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

endmodule

>>> rtl/priority_winner_select.sv
// Priority winner select.
// Input channel (i_valid / o_ready) takes one candidate per item: action id,
// conflict group (0 = none), priority and a batch end mark. While a batch is
// being collected, one candidate is accepted every cycle; each is placed in
// a row of MAX_CANDIDATES sorting cells in the cycle it is accepted
// (descending priority, ties to the lower action id, arrival order on equal
// keys). A candidate arriving when the row is full is dropped and the batch
// overflow flag is set.
// After the batch end item the row drains from its head, one entry a cycle.
// An entry whose nonzero group is already claimed is skipped. Winners leave
// on the output channel (o_valid / i_ready) in sorted order, the last one
// with final_winner set. One winner is held back in a pending slot until the
// next winner or the end of the row is found; it then moves to the output
// register, so each winner passes the pending slot and the output register.
// o_ready stays low during the drain. A stalled receiver holds the output
// register and stops further winners from leaving the row; nothing is lost.
// Reset empties the row and clears the group mask and overflow flag.
module priority_winner_select (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [pws_pkg::ACTION_W-1:0] i_action_id,
    input  logic [pws_pkg::GROUP_W-1:0]  i_group_id,
    input  logic [pws_pkg::PRIO_W-1:0]   i_prio,
    input  logic                         i_batch_end,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [pws_pkg::ACTION_W-1:0] o_win_action,
    output logic [pws_pkg::GROUP_W-1:0]  o_win_group,
    output logic [pws_pkg::PRIO_W-1:0]   o_win_prio,
    output logic                         o_final_winner,
    output logic                         o_overflowed
);
    import pws_pkg::*;

    t_entry     cand;
    t_cell_ctrl ctrl;
    t_entry     cell_entry [MAX_CANDIDATES];
    logic [MAX_CANDIDATES-1:0] cell_valid;
    logic [MAX_CANDIDATES-1:0] cell_ins;

    logic                  r_drain;
    logic [NUM_GROUPS-1:0] r_groups;
    logic                  r_overflow;
    t_entry                r_pend;
    logic                  r_pend_valid;
    t_entry                r_out;
    logic                  r_out_valid;
    logic                  r_out_final;
    logic                  r_out_ovf;

    logic                  accept;
    logic                  full;
    logic                  out_free;
    t_entry                head;
    logic                  head_valid;
    logic [NUM_GROUPS-1:0] head_bit;
    logic                  head_blocked;
    logic                  take_head;
    logic                  finish;

    assign cand     = '{action: i_action_id, group: i_group_id, prio: i_prio};
    assign o_ready  = !r_drain;
    assign accept   = i_valid && o_ready;
    assign full     = cell_valid[MAX_CANDIDATES-1];
    assign out_free = !r_out_valid || i_ready;

    assign head         = cell_entry[0];
    assign head_valid   = cell_valid[0];
    assign head_bit     = group_bit(head.group);
    assign head_blocked = (head.group != GROUP_NONE) && ((r_groups & head_bit) != '0);
    // Winner moves into the pending slot, pushing the old one out if any
    assign take_head    = r_drain && head_valid && !head_blocked
                          && (!r_pend_valid || out_free);
    assign finish       = r_drain && !head_valid && r_pend_valid && out_free;

    assign ctrl.insert = accept && !full;
    assign ctrl.pop    = r_drain && head_valid && (head_blocked || take_head);

    // Row of sorting cells
    for (genvar k = 0; k < MAX_CANDIDATES; k++) begin : g_cell
        t_entry prev_entry;
        logic   prev_valid;
        logic   prev_ins;
        t_entry next_entry;
        logic   next_valid;

        if (k == 0) begin : g_first
            assign prev_entry = cand;
            assign prev_valid = 1'b0;
            assign prev_ins   = 1'b0;
        end else begin : g_mid
            assign prev_entry = cell_entry[k-1];
            assign prev_valid = cell_valid[k-1];
            assign prev_ins   = cell_ins[k-1];
        end

        if (k == MAX_CANDIDATES - 1) begin : g_last
            assign next_entry = cand;
            assign next_valid = 1'b0;
        end else begin : g_inner
            assign next_entry = cell_entry[k+1];
            assign next_valid = cell_valid[k+1];
        end

        pws_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_cand       (cand),
            .i_ctrl       (ctrl),
            .i_prev_entry (prev_entry),
            .i_prev_valid (prev_valid),
            .i_prev_ins   (prev_ins),
            .i_next_entry (next_entry),
            .i_next_valid (next_valid),
            .o_entry      (cell_entry[k]),
            .o_valid      (cell_valid[k]),
            .o_ins        (cell_ins[k])
        );
    end

    // Batch control, group mask, pending winner and output register
    always_ff @(posedge i_clk) begin
        if (take_head) begin
            r_pend <= head;
        end
        if ((take_head && r_pend_valid) || finish) begin
            r_out       <= r_pend;
            r_out_final <= finish;
            r_out_ovf   <= r_overflow;
        end
        if (!i_rst_n) begin
            r_drain      <= 1'b0;
            r_groups     <= '0;
            r_overflow   <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept && full) begin
                r_overflow <= 1'b1;
            end
            if (accept && i_batch_end) begin
                r_drain <= 1'b1;
            end
            if (take_head && (head.group != GROUP_NONE)) begin
                r_groups <= r_groups | head_bit;
            end
            if (take_head) begin
                r_pend_valid <= 1'b1;
            end
            if ((take_head && r_pend_valid) || finish) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            if (finish) begin
                r_drain      <= 1'b0;
                r_groups     <= '0;
                r_overflow   <= 1'b0;
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_win_action   = r_out.action;
    assign o_win_group    = r_out.group;
    assign o_win_prio     = r_out.prio;
    assign o_final_winner = r_out_final;
    assign o_overflowed   = r_out_ovf;

    // Occupied cells always form a prefix of the row
    a_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (({1'b0, cell_valid} & ({1'b0, cell_valid} + 1'b1)) == '0))
        else $error("occupied cells are not contiguous");

    // Outside a drain no group is claimed and no winner is pending
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_drain |-> (r_groups == '0) && !r_pend_valid)
        else $error("batch state left over outside a drain");

    // Once the row is empty during a drain a winner is always pending
    a_pend_at_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_drain && !head_valid) |-> r_pend_valid)
        else $error("drain emptied without a pending winner");

    // Drain ends as soon as the last winner moves to the output
    a_drain_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        finish |=> !r_drain && o_valid && o_final_winner)
        else $error("drain did not end with a final winner");

endmodule
